// File: rtl/core/svar_pkg.sv
// svar_pkg: shared types, constants and helper functions for the servo angle ramp.
// No dependencies; imported by every rtl/core module.
package svar_pkg;

  localparam int unsigned NumChannels = 8;

  localparam logic [7:0]  AngleMax  = 8'd180;
  localparam logic [7:0]  AngleMid  = 8'd90;
  localparam logic [11:0] PulseBase = 12'd500;

  typedef enum logic [1:0] {
    FUNC_MOVE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_NUDGE = 2'd2
  } svar_func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] channel;
    logic [7:0] target_angle;
    logic [7:0] step_size;
    logic       nudge_up;
    logic [7:0] low_limit;
  } svar_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [7:0]  current_angle;
    logic [11:0] pulse_us;
    logic        move_done;
  } svar_res_t;

  // power-on angle of a channel; channels past the first eight park mid-travel
  function automatic logic [7:0] reset_angle(input int unsigned idx);
    logic [7:0] a;
    case (idx)
      0:       a = 8'd15;
      1:       a = 8'd170;
      2:       a = 8'd78;
      3:       a = 8'd15;
      4:       a = 8'd90;
      5:       a = 8'd176;
      6:       a = 8'd0;
      7:       a = 8'd90;
      default: a = AngleMid;
    endcase
    return a;
  endfunction

  // 500 + floor(angle*100/9) = 500 + 11*angle + floor(angle/9);
  // floor(angle/9) == (angle*57) >> 9 for every 8-bit angle
  function automatic logic [11:0] pulse_width(input logic [7:0] ang);
    logic [13:0] m57;
    logic [11:0] m11;
    m57 = 14'(ang) * 14'd57;
    m11 = 12'(ang) * 12'd11;
    return PulseBase + m11 + 12'(m57[13:9]);
  endfunction

endpackage

// File: rtl/core/svar_ifs.sv
// svar_ifs: valid/ready channel interfaces for commands, results and configuration.
// No dependencies; field widths match those in svar_pkg.
interface svar_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] channel;
  logic [7:0] target_angle;
  logic [7:0] step_size;
  logic       nudge_up;
  logic [7:0] low_limit;

  modport source (output valid, func, channel, target_angle, step_size, nudge_up,
                  low_limit, input ready);
  modport sink   (input valid, func, channel, target_angle, step_size, nudge_up,
                  low_limit, output ready);
endinterface

interface svar_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_channel;
  logic [7:0]  current_angle;
  logic [11:0] pulse_us;
  logic        move_done;

  modport source (output valid, out_channel, current_angle, pulse_us, move_done,
                  input ready);
  modport sink   (input valid, out_channel, current_angle, pulse_us, move_done,
                  output ready);
endinterface

interface svar_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] step_interval;

  modport source (output valid, step_interval, input ready);
  modport sink   (input valid, step_interval, output ready);
endinterface

// File: rtl/core/svar_in_stage.sv
// svar_in_stage: input register for command/tick transactions.
// Depends on svar_pkg (svar_item_t).
module svar_in_stage
  import svar_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  svar_item_t item_i,
  input  logic       adv_i,
  output logic       valid_o,
  output svar_item_t item_o
);

  logic       vld_q, vld_d;
  svar_item_t item_q;
  logic       take;

  assign ready_o = !vld_q || adv_i;
  assign take    = valid_i && ready_o;
  assign vld_d   = take || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/svar_core.sv
// svar_core: angle table, ramp state, tick divider and one-step ramp datapath.
// Depends on svar_pkg (types, limits, reset angles, pulse-width function).
module svar_core
  import svar_pkg::*;
#(
  parameter int unsigned CHANNELS = NumChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_interval_i,
  input  logic       adv_i,
  input  svar_item_t item_i,
  output logic       res_vld_o,
  output svar_res_t  res_o
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0] table_q [CHANNELS];
  logic       act_q, act_d;
  logic [2:0] rch_q, rch_d;
  logic [7:0] rtgt_q, rtgt_d;
  logic [7:0] rstep_q, rstep_d;
  logic [7:0] rcur_q, rcur_d;
  logic [9:0] tcnt_q, tcnt_d;
  logic [9:0] intv_q;

  logic       ch_ok;
  logic [7:0] cmd_cur, mv_tgt, lo, nd_tgt, arm_tgt, arm_step;
  logic       is_cmd, is_tick;
  logic [9:0] cnt_inc, intv_eff;
  logic       step_now;
  logic [8:0] sum;
  logic [7:0] diff, new_up, new_dn, new_ang;
  logic       wr_en;

  assign ch_ok   = 32'(item_i.channel) < CHANNELS;
  assign cmd_cur = table_q[ChW'(item_i.channel)];
  assign mv_tgt  = (item_i.target_angle > AngleMax) ? AngleMax : item_i.target_angle;
  assign lo      = (item_i.low_limit > AngleMax) ? AngleMax : item_i.low_limit;

  // nudge: +1 saturating at the top, -1 floored at the low limit
  always_comb begin
    if (item_i.nudge_up) begin
      nd_tgt = (cmd_cur >= AngleMax - 8'd1) ? AngleMax : cmd_cur + 8'd1;
    end else begin
      nd_tgt = ({1'b0, cmd_cur} <= {1'b0, lo} + 9'd1) ? lo : cmd_cur - 8'd1;
    end
  end

  always_comb begin
    is_cmd   = 1'b0;
    is_tick  = 1'b0;
    arm_tgt  = nd_tgt;
    arm_step = 8'd1;
    case (svar_func_e'(item_i.func))
      FUNC_MOVE: begin
        is_cmd   = ch_ok;
        arm_tgt  = mv_tgt;
        arm_step = (item_i.step_size == 8'd0) ? 8'd1 : item_i.step_size;
      end
      FUNC_NUDGE: begin
        is_cmd = ch_ok;
      end
      FUNC_TICK: begin
        is_tick = act_q;
      end
      default: begin
        is_cmd = 1'b0;
      end
    endcase
  end

  assign cnt_inc  = tcnt_q + 10'd1;
  assign intv_eff = (intv_q == 10'd0) ? 10'd1 : intv_q;
  assign step_now = is_tick && (cnt_inc >= intv_eff);

  // one ramp step, clamped at the target
  assign sum     = {1'b0, rcur_q} + {1'b0, rstep_q};
  assign new_up  = (sum > {1'b0, rtgt_q}) ? rtgt_q : sum[7:0];
  assign diff    = rcur_q - rtgt_q;
  assign new_dn  = (diff <= rstep_q) ? rtgt_q : rcur_q - rstep_q;
  assign new_ang = (rtgt_q > rcur_q) ? new_up : new_dn;
  assign wr_en   = adv_i && step_now;

  always_comb begin
    act_d   = act_q;
    rch_d   = rch_q;
    rtgt_d  = rtgt_q;
    rstep_d = rstep_q;
    rcur_d  = rcur_q;
    tcnt_d  = tcnt_q;
    if (adv_i && is_cmd) begin
      tcnt_d = 10'd0;
      if (arm_tgt == cmd_cur) begin
        act_d = 1'b0;
      end else begin
        act_d   = 1'b1;
        rch_d   = item_i.channel;
        rtgt_d  = arm_tgt;
        rstep_d = arm_step;
        rcur_d  = cmd_cur;
      end
    end else if (adv_i && is_tick) begin
      if (step_now) begin
        tcnt_d = 10'd0;
        rcur_d = new_ang;
        act_d  = (new_ang != rtgt_q);
      end else begin
        tcnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      rch_q   <= 3'd0;
      rtgt_q  <= 8'd0;
      rstep_q <= 8'd1;
      rcur_q  <= 8'd0;
      tcnt_q  <= 10'd0;
      intv_q  <= 10'd1;
    end else begin
      act_q   <= act_d;
      rch_q   <= rch_d;
      rtgt_q  <= rtgt_d;
      rstep_q <= rstep_d;
      rcur_q  <= rcur_d;
      tcnt_q  <= tcnt_d;
      if (cfg_we_i) begin
        intv_q <= cfg_interval_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        table_q[i] <= reset_angle(i);
      end
    end else if (wr_en) begin
      table_q[ChW'(rch_q)] <= new_ang;
    end
  end

  assign res_vld_o           = step_now;
  assign res_o.out_channel   = rch_q;
  assign res_o.current_angle = new_ang;
  assign res_o.pulse_us      = pulse_width(new_ang);
  assign res_o.move_done     = (new_ang == rtgt_q);

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (rstep_q != 8'd0))
    else $error("armed ramp with zero step");

  a_armed_not_there: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (rcur_q != rtgt_q))
    else $error("ramp armed although already at target");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && res_o.move_done) |=> !act_q)
    else $error("ramp still armed after final step");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (rtgt_q <= AngleMax && rcur_q <= AngleMax))
    else $error("ramp angle out of range");

endmodule

// File: rtl/core/svar_out_stage.sv
// svar_out_stage: result register holding one step transaction until taken.
// Depends on svar_pkg (svar_res_t).
module svar_out_stage
  import svar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  svar_res_t res_i,
  output logic      valid_o,
  input  logic      ready_i,
  output svar_res_t res_o
);

  logic      vld_q, vld_d;
  svar_res_t res_q;

  assign vld_d = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// File: rtl/core/servo_angle_ramp_top.sv
// servo_angle_ramp_top: slew-limited servo positioner, one command or tick per cycle
// while no result is stalled. A tick that steps is registered in the input register on
// acceptance; its result is then loaded into the result register, where it can be taken.
// Throughput: one transaction per cycle; the input register advances whenever the result
// register is empty or being drained, so ready drops only while a result is stalled.
// Reset (rst_ni, async low): angle table to power-on angles, ramp disarmed, step 1,
// tick counter 0, step interval 1; both stages empty.
module servo_angle_ramp_top
  import svar_pkg::*;
#(
  parameter int unsigned CHANNELS = NumChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  svar_cfg_if.sink   cfg_i,
  svar_in_if.sink    in_i,
  svar_out_if.source out_o
);

  svar_item_t item_in, item_q;
  logic       in_vld;
  logic       adv;        // input register hands its transaction to the core
  logic       out_vld;
  logic       res_vld;
  svar_res_t  res, res_q;

  // Config register is a plain write, always accepted.
  assign cfg_i.ready = 1'b1;

  assign item_in.func         = in_i.func;
  assign item_in.channel      = in_i.channel;
  assign item_in.target_angle = in_i.target_angle;
  assign item_in.step_size    = in_i.step_size;
  assign item_in.nudge_up     = in_i.nudge_up;
  assign item_in.low_limit    = in_i.low_limit;

  // Core state updates at the same edge the result register loads, so the next
  // queued transaction always sees the table as left by the one before.
  assign adv = in_vld && (!out_vld || out_o.ready);

  svar_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (item_in),
    .adv_i   (adv),
    .valid_o (in_vld),
    .item_o  (item_q)
  );

  svar_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_interval_i (cfg_i.step_interval),
    .adv_i          (adv),
    .item_i         (item_q),
    .res_vld_o      (res_vld),
    .res_o          (res)
  );

  // Only ticks that step produce a result transaction.
  svar_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && res_vld),
    .res_i   (res),
    .valid_o (out_vld),
    .ready_i (out_o.ready),
    .res_o   (res_q)
  );

  assign out_o.valid         = out_vld;
  assign out_o.out_channel   = res_q.out_channel;
  assign out_o.current_angle = res_q.current_angle;
  assign out_o.pulse_us      = res_q.pulse_us;
  assign out_o.move_done     = res_q.move_done;

endmodule
